### src/response_frame_checker_defines.svh
// Assertion macros shared by the response frame checker modules.
`ifndef RESPONSE_FRAME_CHECKER_DEFINES_SVH
`define RESPONSE_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked on clk and idle while arst_n is low.
`define RFC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and idle while arst_n is low.
`define RFC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rfc_pkg.sv
// Package with the types and constants of the response frame checker.
`timescale 1ns / 1ps

package rfc_pkg;

	localparam logic [7:0] HEAD_FIRST  = 8'h57;
	localparam logic [7:0] HEAD_SECOND = 8'hAB;
	localparam logic [5:0] CMD_MASK    = 6'h3F;
	localparam logic [9:0] MIN_SIZE    = 10'd6;
	localparam logic [8:0] COUNT_MAX   = 9'd511;

	// Byte positions inside a frame.
	localparam logic [8:0] IDX_HEAD0 = 9'd0;
	localparam logic [8:0] IDX_HEAD1 = 9'd1;
	localparam logic [8:0] IDX_ADDR  = 9'd2;
	localparam logic [8:0] IDX_CMD   = 9'd3;
	localparam logic [8:0] IDX_LEN   = 9'd4;

	// Status codes reported on the end byte.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_HEADER   = 3'd2;
	localparam logic [2:0] ST_ADDRESS  = 3'd3;
	localparam logic [2:0] ST_COMMAND  = 3'd4;
	localparam logic [2:0] ST_LENGTH   = 3'd5;
	localparam logic [2:0] ST_CHECKSUM = 3'd6;

	// Configuration register indexes.
	localparam logic REG_CMD  = 1'b0;
	localparam logic REG_ADDR = 1'b1;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_chunk;
	} in_word_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       frame_done;
		logic [2:0] status;
	} out_word_t;

	typedef struct packed {
		logic [5:0] expected_command;
		logic [7:0] device_address;
	} cfg_t;

endpackage

### src/rfc_if.sv
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface rfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_chunk;

	modport source (output valid, output rx_byte, output end_of_chunk, input ready);
	modport sink (input valid, input rx_byte, input end_of_chunk, output ready);
endinterface

interface rfc_out_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       frame_done;
	logic [2:0] status;

	modport source (output valid, output payload_valid, output payload_byte,
		output frame_done, output status, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input frame_done, input status, output ready);
endinterface

### src/rfc_cfg.sv
// APB-style configuration registers of the response frame checker.
`timescale 1ns / 1ps

module rfc_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output rfc_pkg::cfg_t cfg
);

	logic [5:0] cmd_q;
	logic [7:0] addr_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q  <= '0;
			addr_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				rfc_pkg::REG_CMD:  cmd_q  <= pwdata[5:0] & rfc_pkg::CMD_MASK;
				rfc_pkg::REG_ADDR: addr_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			rfc_pkg::REG_CMD:  prdata = {26'd0, cmd_q};
			rfc_pkg::REG_ADDR: prdata = {24'd0, addr_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.expected_command = cmd_q;
	assign cfg.device_address   = addr_q;

endmodule

### src/rfc_check.sv
// Frame state registers and the per-byte check logic.
`timescale 1ns / 1ps
`include "response_frame_checker_defines.svh"

module rfc_check (
	input  logic               clk,
	input  logic               arst_n,
	input  rfc_pkg::cfg_t      cfg,
	input  logic               acc,
	input  rfc_pkg::in_word_t  in_word,
	output rfc_pkg::out_word_t res
);

	logic [8:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] len_q;
	logic       hdr_err_q;
	logic       addr_err_q;
	logic       cmd_err_q;

	logic [9:0] size;
	logic [9:0] want_size;
	logic       bad_head0;
	logic       bad_head1;
	logic       bad_addr;
	logic       bad_cmd;

	assign size      = {1'b0, cnt_q} + 10'd1;
	assign want_size = rfc_pkg::MIN_SIZE + {2'd0, len_q};
	assign bad_head0 = in_word.rx_byte != rfc_pkg::HEAD_FIRST;
	assign bad_head1 = in_word.rx_byte != rfc_pkg::HEAD_SECOND;
	assign bad_addr  = in_word.rx_byte != cfg.device_address;
	assign bad_cmd   = (in_word.rx_byte[5:0] & rfc_pkg::CMD_MASK) != cfg.expected_command;

	always_comb begin
		res = '0;
		if (in_word.end_of_chunk) begin
			res.frame_done = 1'b1;
			if (size < rfc_pkg::MIN_SIZE) begin
				res.status = rfc_pkg::ST_SHORT;
			end else if (hdr_err_q) begin
				res.status = rfc_pkg::ST_HEADER;
			end else if (addr_err_q) begin
				res.status = rfc_pkg::ST_ADDRESS;
			end else if (cmd_err_q) begin
				res.status = rfc_pkg::ST_COMMAND;
			end else if (size != want_size) begin
				res.status = rfc_pkg::ST_LENGTH;
			end else if (in_word.rx_byte != sum_q) begin
				res.status = rfc_pkg::ST_CHECKSUM;
			end else begin
				res.status = rfc_pkg::ST_OK;
			end
		end else if (cnt_q > rfc_pkg::IDX_LEN) begin
			res.payload_valid = 1'b1;
			res.payload_byte  = in_word.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			len_q      <= '0;
			hdr_err_q  <= 1'b0;
			addr_err_q <= 1'b0;
			cmd_err_q  <= 1'b0;
		end else if (acc) begin
			if (in_word.end_of_chunk) begin
				cnt_q      <= '0;
				sum_q      <= '0;
				len_q      <= '0;
				hdr_err_q  <= 1'b0;
				addr_err_q <= 1'b0;
				cmd_err_q  <= 1'b0;
			end else begin
				unique case (cnt_q)
					rfc_pkg::IDX_HEAD0: if (bad_head0) hdr_err_q <= 1'b1;
					rfc_pkg::IDX_HEAD1: if (bad_head1) hdr_err_q <= 1'b1;
					rfc_pkg::IDX_ADDR:  if (bad_addr) addr_err_q <= 1'b1;
					rfc_pkg::IDX_CMD:   if (bad_cmd) cmd_err_q <= 1'b1;
					rfc_pkg::IDX_LEN:   len_q <= in_word.rx_byte;
					default: ;
				endcase
				sum_q <= sum_q + in_word.rx_byte;
				if (cnt_q != rfc_pkg::COUNT_MAX) begin
					cnt_q <= cnt_q + 9'd1;
				end
			end
		end
	end

	`RFC_ASSERT_NXT(a_end_clears, acc && in_word.end_of_chunk,
		cnt_q == '0 && sum_q == '0 && !hdr_err_q && !addr_err_q && !cmd_err_q,
		"frame state not cleared after end byte")
	`RFC_ASSERT_NXT(a_count_step, acc && !in_word.end_of_chunk && cnt_q != rfc_pkg::COUNT_MAX,
		cnt_q == $past(cnt_q) + 9'd1, "byte count did not advance")
	`RFC_ASSERT_IMP(a_res_excl, res.payload_valid,
		!res.frame_done && res.status == rfc_pkg::ST_OK && cnt_q > rfc_pkg::IDX_LEN,
		"payload word overlaps end-of-frame report")

endmodule

### src/rfc_out_buf.sv
// Result register with a skid stage between the check logic and the receiver.
`timescale 1ns / 1ps
`include "response_frame_checker_defines.svh"

module rfc_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rfc_pkg::out_word_t in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output rfc_pkg::out_word_t out_word
);

	rfc_pkg::out_word_t out_q;
	rfc_pkg::out_word_t skid_q;
	logic               out_vld_q;
	logic               skid_vld_q;
	logic               in_acc;
	logic               out_free;

	assign in_ready  = !skid_vld_q;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : in_word;
		end else if (in_acc) begin
			skid_q <= in_word;
		end
	end

	`RFC_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q,
		"skid stage holds a word while the result register is empty")
	`RFC_ASSERT_NXT(a_stall_fills_skid, out_vld_q && !out_ready && in_acc,
		skid_vld_q && out_vld_q, "word accepted under stall was not parked")

endmodule

### src/response_frame_checker.sv
// Top level of the response frame checker.
`timescale 1ns / 1ps
// Checks a response frame that arrives one byte per word on in_ch.
// Each input word carries rx_byte and end_of_chunk, which marks the last
// byte. Every input word yields exactly one result word on out_ch: a
// tentative payload byte for frame offsets five and up, or on the end byte
// frame_done with the status of the first failing check.
// The APB port holds expected_command at byte address 0 and device_address
// at byte address 4; write it only while no word is in flight.
// An accepted word is registered in the result register, or in the skid
// stage under a stall; one word is taken every cycle while in_ch.ready is
// high; state update and checks fit between frame and result registers.
// A skid stage behind the result register keeps in_ch ready for one more
// word while out_ch stalls; with both stages full, in_ch.ready drops until
// the receiver takes a word.
// arst_n clears the frame state, both registers and both output stages.

module response_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	rfc_in_if.sink       in_ch,
	rfc_out_if.source    out_ch
);

	rfc_pkg::cfg_t      cfg;
	rfc_pkg::in_word_t  in_word;
	rfc_pkg::out_word_t res;
	rfc_pkg::out_word_t out_word;
	logic               in_acc;

	assign in_word.rx_byte      = in_ch.rx_byte;
	assign in_word.end_of_chunk = in_ch.end_of_chunk;
	assign in_acc               = in_ch.valid && in_ch.ready;

	rfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rfc_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.acc     (in_acc),
		.in_word (in_word),
		.res     (res)
	);

	rfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_word   (res),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_word  (out_word)
	);

	assign out_ch.payload_valid = out_word.payload_valid;
	assign out_ch.payload_byte  = out_word.payload_byte;
	assign out_ch.frame_done    = out_word.frame_done;
	assign out_ch.status        = out_word.status;

endmodule
